[rtl/mf5_pkg.sv]
// Shared types and constants of the 5x5 RGB median filter.
package mf5_pkg;

    localparam int DEF_MAX_WIDTH = 256;
    localparam int BYTE_W        = 8;
    localparam int WIDTH_W       = 9;
    localparam int HEIGHT_W      = 16;
    localparam int ROW_W         = 17;
    localparam int CFG_DATA_W    = 16;
    localparam int WIN           = 5;
    localparam int WIN_N         = WIN * WIN;
    localparam int MED_RANK      = WIN_N / 2;
    localparam int PAD           = WIN - 1;
    localparam int ROWS_STORED   = WIN - 1;
    localparam int PH_W          = $clog2(ROWS_STORED);

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(256);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(256);

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_cfg_idx              index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [BYTE_W-1:0] median_red;
        logic [BYTE_W-1:0] median_green;
        logic [BYTE_W-1:0] median_blue;
        logic              frame_last;
    } t_pix_out;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } t_pixel;

    // Load enables of the median pipeline stages.
    typedef struct packed {
        logic ld3;
        logic ld4;
        logic ld5;
    } t_med_ctl;

endpackage

[rtl/mf5_stream_if.sv]
// Valid/ready channel carrying one payload of type T.
interface mf5_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

[rtl/median_filter_5x5_rgb.sv]
// 5x5 per-channel median filter over a border-padded RGB pixel stream.
//
// Usage: i_pix takes one padded pixel per transaction in raster order; each
// padded row holds image_width + 4 pixels and a frame image_height + 4 rows.
// frame_start on a pixel restarts the row and column counters there; after
// the last padded pixel the counters wrap on their own. o_med gives one
// median pixel for every full 5x5 window, image_width by image_height per
// frame, with frame_last on the final one. Pixels of the first four rows and
// the first four columns of each row only fill the row stores and window.
// i_cfg writes image_width (index 0) and image_height (index 1); write only
// while the filter is idle. i_cfg.ready is always high.
// Throughput: one pixel per cycle unless o_med stalls, set by the single-port
// read/write of the four row memories and the fully pipelined median network.
// Path: the pixel completing its window goes through the row memory read,
// window, compare, rank and select registers before its result is valid.
// Reset: counters clear, registers return to 256 by 256, pipeline empties;
// row memories are not cleared and need no clearing pass.
// Stall: every stage holds while the stage after it is full and held, so bubbles
// collapse and i_pix.ready drops only once the whole pipeline is full and stalled.
module median_filter_5x5_rgb import mf5_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mf5_stream_if.sink    i_pix,
    mf5_stream_if.source  o_med,
    mf5_stream_if.sink    i_cfg
);

    localparam int PAD_ROW = MAX_WIDTH + PAD;
    localparam int AW      = $clog2(PAD_ROW);
    localparam int CW      = $clog2(PAD_ROW + 1);

    // configuration
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;

    // position counters
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    // effective geometry and per-pixel position
    logic [CW-1:0]       w_w_eff;
    logic [CW-1:0]       w_wpad;
    logic [HEIGHT_W-1:0] w_h_eff;
    logic [ROW_W-1:0]    w_hpad;
    logic [CW-1:0]       w_c0;
    logic [CW-1:0]       w_c1;
    logic [CW-1:0]       w_c3;
    logic [ROW_W-1:0]    w_r0;
    logic [ROW_W-1:0]    w_r1;
    logic [ROW_W-1:0]    w_r2;
    logic [ROW_W-1:0]    w_r3;
    logic [CW-1:0]       n_col;
    logic [ROW_W-1:0]    n_row;
    logic [AW-1:0]       w_addr;
    logic [PH_W-1:0]     w_ph;
    logic                w_emit;
    logic                w_last;
    t_pixel              w_pix;

    // pipeline control
    logic w_acc;
    logic w_ld1, w_ld2, w_ld3, w_ld4, w_ld5;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_last1, r_last2, r_last3, r_last4, r_last5;
    logic r_emit1;
    logic [PH_W-1:0] r_ph1;
    t_pixel          r_pix1;

    // row memories and window
    t_pixel r_mem [ROWS_STORED][PAD_ROW];
    t_pixel r_rd  [ROWS_STORED];
    t_pixel w_col [ROWS_STORED];
    t_pixel r_win [WIN][WIN];

    logic [WIN_N-1:0][BYTE_W-1:0] w_red;
    logic [WIN_N-1:0][BYTE_W-1:0] w_green;
    logic [WIN_N-1:0][BYTE_W-1:0] w_blue;
    logic [BYTE_W-1:0]            w_med_red;
    logic [BYTE_W-1:0]            w_med_green;
    logic [BYTE_W-1:0]            w_med_blue;
    t_med_ctl                     w_med_ctl;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg.payload.data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg.payload.data[HEIGHT_W-1:0];
                default:          r_width  <= r_width;
            endcase
        end
    end

    // Clamp width to 1..MAX_WIDTH and height to at least 1.
    always_comb begin
        if (32'(r_width) > MAX_WIDTH) begin
            w_w_eff = CW'(MAX_WIDTH);
        end else if (r_width == '0) begin
            w_w_eff = CW'(1);
        end else begin
            w_w_eff = CW'(r_width);
        end
        w_h_eff = (r_height == '0) ? HEIGHT_W'(1) : r_height;
        w_wpad  = w_w_eff + CW'(PAD);
        w_hpad  = ROW_W'(w_h_eff) + ROW_W'(PAD);
    end

    // ---------------------------------------------------------------
    // Position of the incoming pixel and the counters after it
    // ---------------------------------------------------------------
    always_comb begin
        w_c0 = i_pix.payload.frame_start ? '0 : r_col;
        w_r0 = i_pix.payload.frame_start ? '0 : r_row;
        // a column past the padded width (after a width change) opens a row
        if (w_c0 >= w_wpad) begin
            w_c1 = '0;
            w_r1 = w_r0 + ROW_W'(1);
        end else begin
            w_c1 = w_c0;
            w_r1 = w_r0;
        end
        w_r2 = (w_r1 >= w_hpad) ? '0 : w_r1;

        w_c3 = w_c1 + CW'(1);
        w_r3 = w_r2 + ROW_W'(1);
        if (w_c3 >= w_wpad) begin
            n_col = '0;
            n_row = (w_r3 >= w_hpad) ? '0 : w_r3;
        end else begin
            n_col = w_c3;
            n_row = w_r2;
        end

        w_addr = w_c1[AW-1:0];
        w_ph   = w_r2[PH_W-1:0];
        w_emit = (w_r2 >= ROW_W'(PAD)) && (w_c1 >= CW'(PAD));
        w_last = (w_r2 == w_hpad - ROW_W'(1)) && (w_c1 == w_wpad - CW'(1));
        w_pix  = '{red:   i_pix.payload.red,
                   green: i_pix.payload.green,
                   blue:  i_pix.payload.blue};
    end

    // ---------------------------------------------------------------
    // Pipeline handshake: a stage loads when the next one is empty or
    // loading, so bubbles collapse under a stalled receiver.
    // ---------------------------------------------------------------
    assign w_ld5 = !r_v5 || o_med.ready;
    assign w_ld4 = !r_v4 || w_ld5;
    assign w_ld3 = !r_v3 || w_ld4;
    assign w_ld2 = !r_v2 || w_ld3;
    assign w_ld1 = !r_v1 || w_ld2;

    assign i_pix.ready = w_ld1;
    assign w_acc       = i_pix.valid && w_ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
        end else begin
            if (w_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (w_ld1) r_v1 <= i_pix.valid;
            // only full windows go on to the median network
            if (w_ld2) r_v2 <= r_v1 && r_emit1;
            if (w_ld3) r_v3 <= r_v2;
            if (w_ld4) r_v4 <= r_v3;
            if (w_ld5) r_v5 <= r_v4;
        end
    end

    // Stage 1: read all four row memories at the column, then overwrite the
    // oldest row with the new pixel (read data is the value before the write).
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            for (int m = 0; m < ROWS_STORED; m++) begin
                r_rd[m] <= r_mem[m][w_addr];
                if (w_ph == PH_W'(m)) begin
                    r_mem[m][w_addr] <= w_pix;
                end
            end
            r_pix1  <= w_pix;
            r_ph1   <= w_ph;
            r_emit1 <= w_emit;
            r_last1 <= w_last;
        end
    end

    // Reorder memory outputs oldest row first.
    always_comb begin
        for (int k = 0; k < ROWS_STORED; k++) begin
            w_col[k] = r_rd[PH_W'(r_ph1 + PH_W'(k))];
        end
    end

    // Stage 2: shift the window one column left and append the new column.
    always_ff @(posedge i_clk) begin
        if (w_ld2 && r_v1) begin
            for (int row = 0; row < WIN; row++) begin
                for (int col = 0; col < WIN - 1; col++) begin
                    r_win[row][col] <= r_win[row][col + 1];
                end
            end
            for (int k = 0; k < ROWS_STORED; k++) begin
                r_win[k][WIN - 1] <= w_col[k];
            end
            r_win[WIN - 1][WIN - 1] <= r_pix1;
            r_last2 <= r_last1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld3) r_last3 <= r_last2;
        if (w_ld4) r_last4 <= r_last3;
        if (w_ld5) r_last5 <= r_last4;
    end

    // ---------------------------------------------------------------
    // Stages 3 to 5: median of each channel
    // ---------------------------------------------------------------
    always_comb begin
        for (int row = 0; row < WIN; row++) begin
            for (int col = 0; col < WIN; col++) begin
                w_red[row * WIN + col]   = r_win[row][col].red;
                w_green[row * WIN + col] = r_win[row][col].green;
                w_blue[row * WIN + col]  = r_win[row][col].blue;
            end
        end
    end

    assign w_med_ctl = '{ld3: w_ld3, ld4: w_ld4, ld5: w_ld5};

    mf5_median u_med_red (
        .i_clk    (i_clk),
        .i_ctl    (w_med_ctl),
        .i_byte   (w_red),
        .o_median (w_med_red)
    );

    mf5_median u_med_green (
        .i_clk    (i_clk),
        .i_ctl    (w_med_ctl),
        .i_byte   (w_green),
        .o_median (w_med_green)
    );

    mf5_median u_med_blue (
        .i_clk    (i_clk),
        .i_ctl    (w_med_ctl),
        .i_byte   (w_blue),
        .o_median (w_med_blue)
    );

    // Hold the result until the receiver takes it.
    assign o_med.valid                = r_v5;
    assign o_med.payload.median_red   = w_med_red;
    assign o_med.payload.median_green = w_med_green;
    assign o_med.payload.median_blue  = w_med_blue;
    assign o_med.payload.frame_last   = r_last5;

endmodule

[rtl/mf5_median.sv]
// Three-stage rank-select median of 25 bytes.
module mf5_median import mf5_pkg::*; (
    input  logic                         i_clk,
    input  t_med_ctl                     i_ctl,
    input  logic [WIN_N-1:0][BYTE_W-1:0] i_byte,
    output logic [BYTE_W-1:0]            o_median
);

    // r_bef[j][i]: byte i sorts ahead of byte j (ties broken by position)
    logic [WIN_N-1:0][WIN_N-1:0]  r_bef;
    logic [WIN_N-1:0][WIN_N-1:0]  n_bef;
    logic [WIN_N-1:0][BYTE_W-1:0] r_b3;
    logic [WIN_N-1:0][BYTE_W-1:0] r_b4;
    logic [WIN_N-1:0]             r_sel;
    logic [WIN_N-1:0]             n_sel;
    logic [BYTE_W-1:0]            r_med;
    logic [BYTE_W-1:0]            n_med;

    always_comb begin
        for (int j = 0; j < WIN_N; j++) begin
            for (int i = 0; i < WIN_N; i++) begin
                if (i < j) begin
                    n_bef[j][i] = (i_byte[i] <= i_byte[j]);
                end else if (i > j) begin
                    n_bef[j][i] = (i_byte[i] < i_byte[j]);
                end else begin
                    n_bef[j][i] = 1'b0;
                end
            end
        end
    end

    // the byte with exactly MED_RANK bytes ahead of it is the median
    always_comb begin
        for (int j = 0; j < WIN_N; j++) begin
            n_sel[j] = ($countones(r_bef[j]) == MED_RANK);
        end
    end

    always_comb begin
        n_med = '0;
        for (int j = 0; j < WIN_N; j++) begin
            n_med = n_med | (r_b4[j] & {BYTE_W{r_sel[j]}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_bef <= n_bef;
            r_b3  <= i_byte;
        end
        if (i_ctl.ld4) begin
            r_sel <= n_sel;
            r_b4  <= r_b3;
        end
        if (i_ctl.ld5) begin
            r_med <= n_med;
        end
    end

    assign o_median = r_med;

endmodule
